FILE: hw/rtl/tgbi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tgbi_pkg
// shared types and constants for the grid interpolation unit
// ----------------------------------------------------------------------------
package tgbi_pkg;
    localparam int MaxQ3BinsDef = 64;
    localparam int MaxQ0BinsDef = 64;
    localparam int Components   = 5;

    localparam logic [1:0] REG_Q3_COUNT = 2'd0;
    localparam logic [1:0] REG_Q0_COUNT = 2'd1;
    localparam logic [1:0] REG_Q3_INVW  = 2'd2;
    localparam logic [1:0] REG_Q0_INVW  = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_CMP = 2'd1;
    localparam logic [1:0] ST_OUTSIDE = 2'd2;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic [6:0]  q3_count;
        logic [6:0]  q0_count;
        logic [31:0] q3_invw;
        logic [31:0] q0_invw;
    } cfg_t;
endpackage
`default_nettype wire

FILE: hw/rtl/tgbi_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tgbi channel interfaces
// valid/ready channels for input words, result words and config writes
// ----------------------------------------------------------------------------
interface tgbi_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [14:0] entry_index;
    logic signed [31:0] entry_value;
    logic [1:0]  row_index;
    logic [1:0]  column_index;
    logic [31:0] q3_coordinate;
    logic [31:0] q0_coordinate;
    modport source (output valid, kind, entry_index, entry_value, row_index,
                    column_index, q3_coordinate, q0_coordinate, input ready);
    modport sink (input valid, kind, entry_index, entry_value, row_index,
                  column_index, q3_coordinate, q0_coordinate, output ready);
endinterface

interface tgbi_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] interpolated_value;
    logic [1:0]  status;
    modport source (output valid, interpolated_value, status, input ready);
    modport sink (input valid, interpolated_value, status, output ready);
endinterface

interface tgbi_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/tgbi_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tgbi_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module tgbi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/tgbi_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tgbi_front
// accepts words, classifies them and computes bins, fractions and corner
// addresses; hands each word on through a small queue
// ----------------------------------------------------------------------------
module tgbi_front
    import tgbi_pkg::*;
#(
    parameter int MAX_Q3_BINS = MaxQ3BinsDef,
    parameter int MAX_Q0_BINS = MaxQ0BinsDef,
    localparam int Depth = MAX_Q3_BINS * MAX_Q0_BINS * Components,
    localparam int AW = $clog2(Depth),
    localparam int QW = 2 + 1 + 32 + AW + 1 + 2 * 16 + 4 * AW
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire cfg_t   cfg,
    tgbi_in_if.sink     in_ch,
    output logic        q_valid,
    input  wire logic   q_ready,
    output logic [QW-1:0] q_data
);
    localparam int B3W = $clog2(MAX_Q3_BINS) + 1;
    localparam int B0W = $clog2(MAX_Q0_BINS) + 1;

    // stage 1: multiply
    logic        s1_valid_reg;
    logic        s1_kind_reg;
    logic [14:0] s1_widx_reg;
    logic [31:0] s1_wval_reg;
    logic [2:0]  s1_comp_reg;
    logic        s1_bad_reg;
    logic [63:0] s1_p3_reg, s1_p0_reg;
    logic [B3W-1:0] s1_n3_reg;
    logic [B0W-1:0] s1_n0_reg;

    // queue
    localparam int QD = 4;
    logic [QW-1:0] fifo_reg [QD];
    logic [1:0]    wp_reg, rp_reg;
    logic [2:0]    cnt_reg;

    logic adv;
    logic push;
    logic pop;
    logic [2:0] comp;
    logic bad;
    logic [B3W-1:0] n3c;
    logic [B0W-1:0] n0c;

    // the multiply stage never stalls: accept while the queue has room
    // for everything in flight
    assign in_ch.ready = (cnt_reg + {2'b0, s1_valid_reg}) < 3'(QD);
    assign adv = in_ch.valid && in_ch.ready;

    always_comb
    begin
        bad = 1'b0;
        comp = 3'd0;
        case ({in_ch.row_index, in_ch.column_index})
            4'b0000: comp = 3'd0;
            4'b0011: comp = 3'd1;
            4'b0101: comp = 3'd2;
            4'b0110: comp = 3'd3;
            4'b1111: comp = 3'd4;
            default: bad = 1'b1;
        endcase
        n3c = (32'(cfg.q3_count) > 32'(MAX_Q3_BINS)) ? B3W'(MAX_Q3_BINS)
                                                     : B3W'(cfg.q3_count);
        n0c = (32'(cfg.q0_count) > 32'(MAX_Q0_BINS)) ? B0W'(MAX_Q0_BINS)
                                                     : B0W'(cfg.q0_count);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= adv;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_kind_reg <= in_ch.kind;
            s1_widx_reg <= in_ch.entry_index;
            s1_wval_reg <= in_ch.entry_value;
            s1_comp_reg <= comp;
            s1_bad_reg  <= bad;
            s1_p3_reg   <= 64'(in_ch.q3_coordinate) * 64'(cfg.q3_invw);
            s1_p0_reg   <= 64'(in_ch.q0_coordinate) * 64'(cfg.q0_invw);
            s1_n3_reg   <= n3c;
            s1_n0_reg   <= n0c;
        end
    end

    // stage 2: bins, range check, corner addresses (small multiply by count)
    logic [31:0] b3, b0;
    logic [15:0] f3, f0;
    logic        outside;
    logic [1:0]  st;
    logic [AW-1:0] a00, a10, a01, a11;
    logic        wr_ok;
    logic [QW-1:0] pkt;
    logic [AW+1:0] row0, row1;

    always_comb
    begin
        b3 = s1_p3_reg[63:32];
        b0 = s1_p0_reg[63:32];
        f3 = s1_p3_reg[31:16];
        f0 = s1_p0_reg[31:16];
        outside = (s1_n3_reg < B3W'(2)) || (s1_n0_reg < B0W'(2))
               || (b3 >= 32'(s1_n3_reg) - 32'd1) || (b0 >= 32'(s1_n0_reg) - 32'd1);
        st = s1_bad_reg ? ST_BAD_CMP : (outside ? ST_OUTSIDE : ST_OK);
        row0 = (AW+2)'((32'(b3[B3W-1:0]) * 32'(s1_n0_reg) + 32'(b0[B0W-1:0]))
                       * Components + 32'(s1_comp_reg));
        row1 = row0 + (AW+2)'(32'(s1_n0_reg) * Components);
        a00 = AW'(row0);
        a01 = AW'(row0 + (AW+2)'(Components));
        a10 = AW'(row1);
        a11 = AW'(row1 + (AW+2)'(Components));
        wr_ok = 32'(s1_widx_reg) < 32'(Depth);
        pkt = {st, s1_kind_reg, s1_wval_reg, AW'(s1_widx_reg), wr_ok,
               f3, f0, a00, a10, a01, a11};
    end

    assign push = s1_valid_reg;
    assign pop  = q_valid && q_ready;
    assign q_valid = cnt_reg != 3'd0;
    assign q_data  = fifo_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 2'd0;
            rp_reg  <= 2'd0;
            cnt_reg <= 3'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + 2'd1;
            end
            if (pop)
            begin
                rp_reg <= rp_reg + 2'd1;
            end
            cnt_reg <= cnt_reg + {2'b0, push} - {2'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wp_reg] <= pkt;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 3'(QD))
        else $error("queue overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> cnt_reg + {2'b0, s1_valid_reg} < 3'(QD))
        else $error("accept with no room");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 3'd0 && !s1_valid_reg) |=> !q_valid || $past(adv) == 1'b0)
        else $error("spurious queue word");
endmodule
`default_nettype wire

FILE: hw/rtl/tgbi_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tgbi_back
// performs table writes, reads four corners from four table copies and blends
// ----------------------------------------------------------------------------
module tgbi_back
    import tgbi_pkg::*;
#(
    parameter int MAX_Q3_BINS = MaxQ3BinsDef,
    parameter int MAX_Q0_BINS = MaxQ0BinsDef,
    localparam int Depth = MAX_Q3_BINS * MAX_Q0_BINS * Components,
    localparam int AW = $clog2(Depth),
    localparam int QW = 2 + 1 + 32 + AW + 1 + 2 * 16 + 4 * AW
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   q_valid,
    output logic        q_ready,
    input  wire logic [QW-1:0] q_data,
    tgbi_out_if.source  out_ch
);
    // four full copies of the table give four corner reads per cycle while not stalled
    logic [1:0]  st;
    logic        kind;
    logic [31:0] wval;
    logic [AW-1:0] widx;
    logic        wr_ok;
    logic [15:0] f3, f0;
    logic [AW-1:0] a00, a10, a01, a11;
    assign {st, kind, wval, widx, wr_ok, f3, f0, a00, a10, a01, a11} = q_data;

    // pipeline: p1 ram read, p2 weights, p3 products, then sum into out reg
    logic p1_v_reg, p2_v_reg, p3_v_reg;
    logic [1:0] p1_st_reg, p2_st_reg, p3_st_reg;
    logic [15:0] p1_f3_reg, p1_f0_reg;
    logic [31:0] rd [4];
    logic [16:0] w3, w0, v3, v0;
    logic [32:0] wt_a_reg, wt_b_reg, wt_c_reg, wt_d_reg;
    logic [31:0] e_reg [4];
    logic signed [63:0] m_reg [4];
    logic signed [63:0] sum;
    logic [31:0] res_reg;
    logic [1:0]  ost_reg;
    logic        ov_reg;
    logic        w1_v_reg;
    logic        go;
    logic        rd_go;
    logic        stall;
    logic [AW-1:0] raddr [4];

    assign stall = ov_reg && !out_ch.ready && p3_v_reg;
    assign q_ready = !stall;
    assign go = q_valid && q_ready;
    assign rd_go = go && kind == KIND_QUERY;
    assign raddr[0] = a00;
    assign raddr[1] = a10;
    assign raddr[2] = a01;
    assign raddr[3] = a11;

    genvar g;
    generate
        for (g = 0; g < 4; g++)
        begin : g_bank
            tgbi_ram #(.WIDTH(32), .DEPTH(Depth)) u_ram (
                .clk     (clk),
                .wr_en   (go && kind == KIND_WRITE && wr_ok),
                .wr_addr (widx),
                .wr_data (wval),
                .rd_en   (rd_go && st == ST_OK),
                .rd_addr (raddr[g]),
                .rd_data (rd[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
            p3_v_reg <= 1'b0;
            ov_reg   <= 1'b0;
            w1_v_reg <= 1'b0;
        end
        else if (!stall)
        begin
            p1_v_reg <= rd_go;
            p2_v_reg <= p1_v_reg;
            p3_v_reg <= p2_v_reg;
            w1_v_reg <= go && kind == KIND_WRITE;
            ov_reg   <= p3_v_reg || (ov_reg && !out_ch.ready);
        end
    end

    always_comb
    begin
        w3 = 17'h10000 - 17'(p1_f3_reg);
        w0 = 17'h10000 - 17'(p1_f0_reg);
        v3 = 17'(p1_f3_reg);
        v0 = 17'(p1_f0_reg);
        sum = m_reg[0] + m_reg[1] + m_reg[2] + m_reg[3];
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            p1_st_reg <= st;
            p1_f3_reg <= f3;
            p1_f0_reg <= f0;
            p2_st_reg <= p1_st_reg;
            wt_a_reg  <= 33'(w3 * w0);
            wt_b_reg  <= 33'(v3 * w0);
            wt_c_reg  <= 33'(w3 * v0);
            wt_d_reg  <= 33'(v3 * v0);
            for (int i = 0; i < 4; i++)
            begin
                e_reg[i] <= rd[i];
            end
            p3_st_reg <= p2_st_reg;
            m_reg[0] <= 64'($signed(e_reg[0]) * $signed({1'b0, wt_a_reg}));
            m_reg[1] <= 64'($signed(e_reg[1]) * $signed({1'b0, wt_b_reg}));
            m_reg[2] <= 64'($signed(e_reg[2]) * $signed({1'b0, wt_c_reg}));
            m_reg[3] <= 64'($signed(e_reg[3]) * $signed({1'b0, wt_d_reg}));
            if (p3_v_reg)
            begin
                ost_reg <= p3_st_reg;
                res_reg <= (p3_st_reg == ST_OK) ? sum[63:32] : 32'd0;
            end
        end
    end

    assign out_ch.valid = ov_reg;
    assign out_ch.interpolated_value = res_reg;
    assign out_ch.status = ost_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        stall |=> $stable(res_reg))
        else $error("result changed under stall");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.status != ST_OK) |-> res_reg == 32'd0)
        else $error("error result not zero");
    assert property (@(posedge clk) disable iff (!rst_n)
        !(w1_v_reg && p1_v_reg))
        else $error("write and query in same slot");
endmodule
`default_nettype wire

FILE: hw/rtl/tensor_grid_bilinear_interp_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tensor_grid_bilinear_interp_unit
// bilinear lookup of a five-component table on a q3 by q0 grid
//
//  channel | dir | payload
//  in_ch   | in  | kind, entry_index, entry_value, row/column, q3/q0 coordinate
//  out_ch  | out | interpolated_value, status (one word per query)
//  cfg_ch  | in  | index, data
//
// one word per cycle sustained while the output is not stalled; each query
// passes the multiply on the accept edge, then queue, ram read, weights, products, sum
// four table copies give four corner reads per cycle while not stalled
// reset clears control only; table contents are undefined until written
// output stall holds the back pipeline, the front queue absorbs 4 words
// ----------------------------------------------------------------------------
module tensor_grid_bilinear_interp_unit
    import tgbi_pkg::*;
#(
    parameter int MAX_Q3_BINS = MaxQ3BinsDef,
    parameter int MAX_Q0_BINS = MaxQ0BinsDef
) (
    input  wire logic clk,
    input  wire logic rst_n,
    tgbi_in_if.sink     in_ch,
    tgbi_out_if.source  out_ch,
    tgbi_cfg_if.sink    cfg_ch
);
    localparam int Depth = MAX_Q3_BINS * MAX_Q0_BINS * Components;
    localparam int AW = $clog2(Depth);
    localparam int QW = 2 + 1 + 32 + AW + 1 + 2 * 16 + 4 * AW;

    cfg_t cfg_reg;
    logic q_valid, q_ready;
    logic [QW-1:0] q_data;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.q3_count <= 7'd64;
            cfg_reg.q0_count <= 7'd64;
            cfg_reg.q3_invw  <= 32'd65536;
            cfg_reg.q0_invw  <= 32'd65536;
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                REG_Q3_COUNT: cfg_reg.q3_count <= cfg_ch.data[6:0];
                REG_Q0_COUNT: cfg_reg.q0_count <= cfg_ch.data[6:0];
                REG_Q3_INVW:  cfg_reg.q3_invw  <= cfg_ch.data;
                REG_Q0_INVW:  cfg_reg.q0_invw  <= cfg_ch.data;
                default: ;
            endcase
        end
    end

    tgbi_front #(.MAX_Q3_BINS(MAX_Q3_BINS), .MAX_Q0_BINS(MAX_Q0_BINS)) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .in_ch   (in_ch),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_data  (q_data)
    );

    tgbi_back #(.MAX_Q3_BINS(MAX_Q3_BINS), .MAX_Q0_BINS(MAX_Q0_BINS)) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_data  (q_data),
        .out_ch  (out_ch)
    );
endmodule
`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the grid interpolation unit. A directed table
// covers write-index extremes, corner entry extremes, bad component pairs
// and points outside the grid. Random traffic follows over several register
// settings. Before each in-range query, the bench writes any corner entry
// that has not been written yet. A behavioral predictor checks every result
// word in order, while both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;
    import tgbi_pkg::*;

    localparam int TableDepth = MaxQ3BinsDef * MaxQ0BinsDef * Components;

    typedef struct {
        logic        kind;
        logic [14:0] entry_index;
        logic [31:0] entry_value;
        logic [1:0]  row_index;
        logic [1:0]  column_index;
        logic [31:0] q3_coordinate;
        logic [31:0] q0_coordinate;
        bit          typed;
        logic [31:0] typed_value;
        logic [1:0]  typed_status;
    } word_t;

    typedef struct {
        logic [31:0] value;
        logic [1:0]  status;
    } result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    tgbi_in_if  in_ch ();
    tgbi_out_if out_ch ();
    tgbi_cfg_if cfg_ch ();

    tensor_grid_bilinear_interp_unit i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    always #5 clk = ~clk;

    logic [31:0] grid_copy [TableDepth];
    bit          grid_written [TableDepth];
    cfg_t        cfg_copy;
    result_t     pending_results[$];
    word_t       directed_rows[$];
    int          error_count = 0;
    bit          squeeze_req = 1'b0;

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        error_count++;
    endtask

    function automatic int comp_of(input logic [1:0] r, input logic [1:0] c);
        if (r == 0 && c == 0) return 0;
        if (r == 0 && c == 3) return 1;
        if (r == 1 && c == 1) return 2;
        if (r == 1 && c == 2) return 3;
        if (r == 3 && c == 3) return 4;
        return -1;
    endfunction

    function automatic longint unsigned eff_count(input logic [6:0] c);
        return (c > MaxQ3BinsDef) ? MaxQ3BinsDef : c;
    endfunction

    function automatic longint unsigned corner_addr(input longint unsigned b3,
                                                    input longint unsigned b0,
                                                    input int comp);
        return (b3 * eff_count(cfg_copy.q0_count) + b0) * Components + comp;
    endfunction

    // bin and fraction of a coordinate, status outside when off the interior
    function automatic bit grid_locate(input logic [31:0] c3, input logic [31:0] c0,
                                       output longint unsigned b3,
                                       output longint unsigned b0,
                                       output longint f3, output longint f0);
        longint unsigned p3, p0, n3, n0;
        p3 = longint'(c3) * longint'(cfg_copy.q3_invw);
        p0 = longint'(c0) * longint'(cfg_copy.q0_invw);
        b3 = p3 >> 32;
        b0 = p0 >> 32;
        f3 = (p3 >> 16) & 64'hffff;
        f0 = (p0 >> 16) & 64'hffff;
        n3 = eff_count(cfg_copy.q3_count);
        n0 = eff_count(cfg_copy.q0_count);
        return (n3 >= 2 && n0 >= 2 && b3 < n3 - 1 && b0 < n0 - 1);
    endfunction

    function automatic longint entry_at(input longint unsigned a);
        if (a >= TableDepth) return 0;
        return longint'(signed'(grid_copy[a]));
    endfunction

    function automatic result_t interp_predict(input word_t w);
        result_t r;
        int comp;
        longint unsigned b3, b0;
        longint f3, f0, sum;
        comp = comp_of(w.row_index, w.column_index);
        r.value = '0;
        if (comp < 0) begin
            r.status = ST_BAD_CMP;
            return r;
        end
        if (!grid_locate(w.q3_coordinate, w.q0_coordinate, b3, b0, f3, f0)) begin
            r.status = ST_OUTSIDE;
            return r;
        end
        sum = entry_at(corner_addr(b3, b0, comp)) * ((65536 - f3) * (65536 - f0))
            + entry_at(corner_addr(b3 + 1, b0, comp)) * (f3 * (65536 - f0))
            + entry_at(corner_addr(b3, b0 + 1, comp)) * ((65536 - f3) * f0)
            + entry_at(corner_addr(b3 + 1, b0 + 1, comp)) * (f3 * f0);
        sum = sum >>> 32;
        r.value = sum[31:0];
        r.status = ST_OK;
        return r;
    endfunction

    function automatic logic [31:0] rand_entry();
        case ($urandom_range(0, 9))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return '0;
            3: return 32'hffffffff;
            default: return $urandom();
        endcase
    endfunction

    function automatic int rand_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_word(input word_t w);
        result_t r;
        int gap;
        @(negedge clk);
        in_ch.kind          = w.kind;
        in_ch.entry_index   = w.entry_index;
        in_ch.entry_value   = w.entry_value;
        in_ch.row_index     = w.row_index;
        in_ch.column_index  = w.column_index;
        in_ch.q3_coordinate = w.q3_coordinate;
        in_ch.q0_coordinate = w.q0_coordinate;
        in_ch.valid         = 1'b1;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        if (w.kind == KIND_WRITE) begin
            if (w.entry_index < TableDepth) begin
                grid_copy[w.entry_index] = w.entry_value;
                grid_written[w.entry_index] = 1'b1;
            end
        end else begin
            r = interp_predict(w);
            if (w.typed && (r.value !== w.typed_value || r.status !== w.typed_status))
                report($sformatf("typed row disagrees with predictor at %h/%h",
                                 w.q3_coordinate, w.q0_coordinate));
            pending_results.push_back(r);
        end
        gap = rand_gap();
        if (gap > 0) begin
            @(negedge clk);
            in_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic write_entry(input longint unsigned a, input logic [31:0] v);
        word_t w;
        w = '{default: '0};
        w.kind = KIND_WRITE;
        w.entry_index = a[14:0];
        w.entry_value = v;
        w.row_index = 2'($urandom());
        w.column_index = 2'($urandom());
        w.q3_coordinate = $urandom();
        w.q0_coordinate = $urandom();
        send_word(w);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_ch.index = idx;
        cfg_ch.data  = data;
        cfg_ch.valid = 1'b1;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        case (idx)
            REG_Q3_COUNT: cfg_copy.q3_count = data[6:0];
            REG_Q0_COUNT: cfg_copy.q0_count = data[6:0];
            REG_Q3_INVW:  cfg_copy.q3_invw  = data;
            REG_Q0_INVW:  cfg_copy.q0_invw  = data;
        endcase
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic drain();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic set_phase(input logic [6:0] n3, input logic [6:0] n0,
                             input logic [31:0] w3, input logic [31:0] w0);
        drain();
        write_reg(REG_Q3_COUNT, {25'($urandom()), n3});
        write_reg(REG_Q0_COUNT, {25'($urandom()), n0});
        write_reg(REG_Q3_INVW, w3);
        write_reg(REG_Q0_INVW, w0);
    endtask

    function automatic logic [31:0] aim_coord(input longint unsigned n,
                                              input logic [31:0] invw);
        longint unsigned target, q;
        if (invw == 0 || n < 2 || $urandom_range(0, 9) == 0) return $urandom();
        target = (longint'($urandom_range(0, n - 2)) << 32)
               | (longint'($urandom_range(0, 65535)) << 16) | $urandom_range(0, 65535);
        q = target / invw;
        if (q > 64'hffffffff) return $urandom();
        return q[31:0];
    endfunction

    task automatic random_query();
        word_t w;
        int comp;
        longint unsigned b3, b0, a;
        longint f3, f0;
        w = '{default: '0};
        w.kind = KIND_QUERY;
        w.entry_index = 15'($urandom());
        w.entry_value = $urandom();
        if ($urandom_range(0, 4) == 0) begin
            w.row_index = 2'($urandom());
            w.column_index = 2'($urandom());
        end else begin
            case ($urandom_range(0, 4))
                0: begin w.row_index = 0; w.column_index = 0; end
                1: begin w.row_index = 0; w.column_index = 3; end
                2: begin w.row_index = 1; w.column_index = 1; end
                3: begin w.row_index = 1; w.column_index = 2; end
                default: begin w.row_index = 3; w.column_index = 3; end
            endcase
        end
        if ($urandom_range(0, 9) < 8) begin
            w.q3_coordinate = aim_coord(eff_count(cfg_copy.q3_count), cfg_copy.q3_invw);
            w.q0_coordinate = aim_coord(eff_count(cfg_copy.q0_count), cfg_copy.q0_invw);
        end else begin
            w.q3_coordinate = $urandom_range(0, 1) ? 32'hffffffff : $urandom();
            w.q0_coordinate = $urandom_range(0, 1) ? 32'h0 : $urandom();
        end
        comp = comp_of(w.row_index, w.column_index);
        if (comp >= 0 && grid_locate(w.q3_coordinate, w.q0_coordinate, b3, b0, f3, f0))
        begin
            for (int k = 0; k < 4; k++) begin
                a = corner_addr(b3 + k[0], b0 + k[1], comp);
                if (!grid_written[a]) write_entry(a, rand_entry());
            end
        end
        send_word(w);
    endtask

    task automatic random_block(input int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 3) == 0)
                write_entry($urandom_range(0, 9) == 0 ? $urandom_range(20480, 32767)
                                                      : $urandom_range(0, TableDepth - 1),
                            rand_entry());
            else
                random_query();
        end
    endtask

    task automatic add_row(input logic k, input logic [14:0] a, input logic [31:0] v,
                           input logic [1:0] r, input logic [1:0] c,
                           input logic [31:0] c3, input logic [31:0] c0,
                           input bit typed, input logic [31:0] tv, input logic [1:0] ts);
        word_t w;
        w = '{k, a, v, r, c, c3, c0, typed, tv, ts};
        directed_rows.push_back(w);
    endtask

    // result check
    always @(posedge clk) begin
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                report($sformatf("unexpected word %h/%0d",
                                 out_ch.interpolated_value, out_ch.status));
            end else begin
                result_t e;
                e = pending_results.pop_front();
                if (out_ch.status !== e.status)
                    report($sformatf("status %0d, want %0d", out_ch.status, e.status));
                if (out_ch.interpolated_value !== e.value)
                    report($sformatf("value %h, want %h", out_ch.interpolated_value,
                                     e.value));
            end
        end
    end

    // result side back-pressure
    initial begin
        int run;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (squeeze_req) begin
                out_ch.ready = 1'b0;
                repeat (300) @(negedge clk);
                squeeze_req = 1'b0;
            end
            out_ch.ready = 1'b1;
            run = $urandom_range(0, 20);
            repeat (run) @(negedge clk);
            if ($urandom_range(0, 2) != 0) begin
                out_ch.ready = 1'b0;
                run = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80)
                                                   : $urandom_range(1, 3);
                repeat (run - 1) @(negedge clk);
            end
        end
    end

    initial begin
        #10ms;
        $display("timeout");
        $display("Verification failed");
        $finish;
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.kind = KIND_WRITE;
        in_ch.entry_index = '0;
        in_ch.entry_value = '0;
        in_ch.row_index = '0;
        in_ch.column_index = '0;
        in_ch.q3_coordinate = '0;
        in_ch.q0_coordinate = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_Q3_COUNT;
        cfg_ch.data = '0;
        cfg_copy = '{7'd64, 7'd64, 32'd65536, 32'd65536};
        foreach (grid_copy[i]) grid_copy[i] = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // corners of component 0 around the origin bin, then extremes
        add_row(KIND_WRITE, 15'd0, 32'h7fffffff, 0, 0, 0, 0, 0, 0, 0);
        add_row(KIND_WRITE, 15'd5, 32'h80000000, 0, 0, 0, 0, 0, 0, 0);
        add_row(KIND_WRITE, 15'd320, 32'h0, 0, 0, 0, 0, 0, 0, 0);
        add_row(KIND_WRITE, 15'd325, 32'hffffffff, 0, 0, 0, 0, 0, 0, 0);
        add_row(KIND_WRITE, 15'd32767, 32'h12345678, 3, 3, 0, 0, 0, 0, 0);
        add_row(KIND_WRITE, 15'd20479, 32'h1, 0, 0, 0, 0, 0, 0, 0);
        add_row(KIND_WRITE, 15'd20480, 32'h55aa55aa, 0, 0, 0, 0, 0, 0, 0);
        add_row(KIND_QUERY, 0, 0, 0, 0, 32'h0, 32'h0, 1, 32'h7fffffff, ST_OK);
        add_row(KIND_QUERY, 0, 0, 0, 0, 32'h8000, 32'h0, 0, 0, 0);
        add_row(KIND_QUERY, 0, 0, 0, 0, 32'h0, 32'hffff, 0, 0, 0);
        add_row(KIND_QUERY, 0, 0, 0, 0, 32'h8000, 32'h8000, 0, 0, 0);
        add_row(KIND_QUERY, 0, 0, 0, 0, 32'hffff, 32'hffff, 0, 0, 0);
        add_row(KIND_QUERY, 0, 0, 0, 0, 32'hffffffff, 32'h0, 1, 32'h0, ST_OUTSIDE);
        add_row(KIND_QUERY, 0, 0, 0, 0, 32'h0, 32'hffffffff, 1, 32'h0, ST_OUTSIDE);
        add_row(KIND_QUERY, 0, 0, 0, 0, 32'h3f0000, 32'h0, 1, 32'h0, ST_OUTSIDE);
        add_row(KIND_QUERY, 0, 0, 0, 1, 32'h0, 32'h0, 1, 32'h0, ST_BAD_CMP);
        add_row(KIND_QUERY, 0, 0, 2, 2, 32'hffffffff, 32'hffffffff, 1, 32'h0, ST_BAD_CMP);
        add_row(KIND_QUERY, 0, 0, 3, 0, 32'h0, 32'h0, 1, 32'h0, ST_BAD_CMP);
        add_row(KIND_QUERY, 0, 0, 1, 3, 32'h0, 32'h0, 1, 32'h0, ST_BAD_CMP);
        add_row(KIND_QUERY, 0, 0, 2, 1, 32'h0, 32'h0, 1, 32'h0, ST_BAD_CMP);
        foreach (directed_rows[i]) send_word(directed_rows[i]);

        squeeze_req = 1'b1;
        random_block(130);
        set_phase(7'd2, 7'd2, 32'h0, 32'h0);
        random_block(60);
        set_phase(7'd64, 7'd64, 32'hffffffff, 32'hffffffff);
        random_block(80);
        set_phase(7'd127, 7'd3, 32'h00018000, 32'h00004000);
        random_block(110);
        set_phase(7'd1, 7'd0, $urandom(), $urandom());
        random_block(40);
        set_phase(7'd0, 7'd5, 32'h10000, 32'h10000);
        random_block(30);
        for (int p = 0; p < 6; p++) begin
            set_phase(7'($urandom_range(2, 9)), 7'($urandom_range(2, 9)),
                      $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(4096, 262144),
                      $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(4096, 262144));
            random_block(90);
        end
        drain();
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

FILE: tensor_grid_bilinear_interp_unit.f
hw/rtl/tgbi_pkg.sv
hw/rtl/tgbi_if.sv
hw/rtl/tgbi_ram.sv
hw/rtl/tgbi_front.sv
hw/rtl/tgbi_back.sv
hw/rtl/tensor_grid_bilinear_interp_unit.sv
tb/tb_top.sv
